@@ rtl/oahi_pkg.sv @@
// Package with the shared types, codes and arithmetic helpers of the hash insert unit.
`default_nettype none

package oahi_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TABLE_SIZE = 2'd0;
    localparam logic [1:0] CFG_PROBE_MODE = 2'd1;
    localparam logic [1:0] CFG_STEP_PRIME = 2'd2;

    // Key digit width, padded key width and digit count; the front consumes one digit per cycle.
    localparam int DIGIT_W     = 4;
    localparam int KEY_PAD_W   = 32;
    localparam int KEY_DIGITS  = KEY_PAD_W / DIGIT_W;
    localparam int STEP_W      = 7;

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;

    typedef enum logic [1:0] {
        MODE_LINEAR = 2'd0,
        MODE_QUAD   = 2'd1,
        MODE_DOUBLE = 2'd2
    } t_probe_mode;

    typedef struct packed {
        logic [30:0] key;
        logic        batch_end;
    } t_item;

    typedef struct packed {
        logic [6:0]  slot;
        logic        placed;
        logic [7:0]  probe_collisions;
        logic [15:0] total_collisions;
    } t_result;

    // Effective configuration, with size and prime already clamped to legal values.
    typedef struct packed {
        logic [7:0]  size;
        t_probe_mode mode;
        logic [6:0]  prime;
    } t_cfg;

    // Work handed from the front to the back.
    typedef struct packed {
        logic [7:0] home;
        logic [7:0] step;
        logic       last;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_KEY,
        F_STEP,
        F_PUSH
    } t_fstate;

    typedef enum logic {
        B_IDLE,
        B_PROBE
    } t_bstate;

    // One restoring remainder step: shift in a bit, subtract the modulus once.
    // Requires rem < m on entry, and leaves rem < m.
    function automatic logic [7:0] mod_step(logic [7:0] rem, logic b, logic [7:0] m);
        logic [8:0] s;
        s = {rem, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[7:0];
    endfunction

    // Modular add of two values that are both below the modulus.
    function automatic logic [7:0] add_mod(logic [7:0] a, logic [7:0] b, logic [7:0] m);
        logic [8:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[7:0];
    endfunction

endpackage

`default_nettype wire

@@ rtl/oahi_front.sv @@
// Front end: accepts keys and computes the home slot and the probe step by digit-serial remainders.
`default_nettype none

module oahi_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire oahi_pkg::t_cfg  i_cfg,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire oahi_pkg::t_item i_in_data,
    output logic                 o_job_valid,
    input  wire logic            i_job_ready,
    output oahi_pkg::t_job       o_job
);
    import oahi_pkg::*;

    t_fstate                   r_state, n_state;
    logic [KEY_PAD_W-1:0]      r_key, n_key;
    logic [$clog2(KEY_DIGITS)-1:0] r_cnt, n_cnt;
    logic [7:0]                r_rt, n_rt;
    logic [7:0]                r_rp, n_rp;
    logic [STEP_W-1:0]         r_step, n_step;
    logic [7:0]                r_rs, n_rs;
    logic                      r_last, n_last;

    logic [7:0] prime_w;
    logic [7:0] rt_tmp, rp_tmp, rs_tmp;

    assign prime_w = {1'b0, i_cfg.prime};

    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_cnt       = r_cnt;
        n_rt        = r_rt;
        n_rp        = r_rp;
        n_step      = r_step;
        n_rs        = r_rs;
        n_last      = r_last;
        o_in_ready  = 1'b0;
        o_job_valid = 1'b0;
        rt_tmp      = r_rt;
        rp_tmp      = r_rp;
        rs_tmp      = '0;
        case (r_state)
            F_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_key   = {1'b0, i_in_data.key};
                    n_last  = i_in_data.batch_end;
                    n_rt    = '0;
                    n_rp    = '0;
                    n_cnt   = '0;
                    n_state = F_KEY;
                end
            end
            F_KEY: begin
                // Both remainders walk the key together, most significant digit first.
                for (int i = 0; i < DIGIT_W; i++) begin
                    rt_tmp = mod_step(rt_tmp, r_key[KEY_PAD_W-1-i], i_cfg.size);
                    rp_tmp = mod_step(rp_tmp, r_key[KEY_PAD_W-1-i], prime_w);
                end
                n_rt  = rt_tmp;
                n_rp  = rp_tmp;
                n_key = r_key << DIGIT_W;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == KEY_DIGITS[$clog2(KEY_DIGITS)-1:0] - 1'b1) begin
                    n_step  = i_cfg.prime - rp_tmp[STEP_W-1:0];
                    n_state = F_STEP;
                end
            end
            F_STEP: begin
                // The double hash step is at most seven bits, reduced in one pass.
                for (int i = STEP_W - 1; i >= 0; i--) begin
                    rs_tmp = mod_step(rs_tmp, r_step[i], i_cfg.size);
                end
                n_rs    = rs_tmp;
                n_state = F_PUSH;
            end
            F_PUSH: begin
                o_job_valid = 1'b1;
                if (i_job_ready) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    assign o_job = '{home: r_rt, step: r_rs, last: r_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key  <= n_key;
        r_cnt  <= n_cnt;
        r_rt   <= n_rt;
        r_rp   <= n_rp;
        r_step <= n_step;
        r_rs   <= n_rs;
        r_last <= n_last;
    end

endmodule

`default_nettype wire

@@ rtl/oahi_queue.sv @@
// Short job queue that decouples the front end from the probe engine.
`default_nettype none

module oahi_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push_valid,
    output logic                o_push_ready,
    input  wire oahi_pkg::t_job i_push_data,
    output logic                o_pop_valid,
    input  wire logic           i_pop_ready,
    output oahi_pkg::t_job      o_pop_data
);
    import oahi_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              push, pop;

    assign o_push_ready = (r_count != QUEUE_DEPTH[QPTR_W:0]);
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_data   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/oahi_back.sv @@
// Probe engine: walks the probe sequence over the occupancy bits and registers each result.
`default_nettype none

module oahi_back #(
    parameter int SLOTS = 128
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire oahi_pkg::t_cfg i_cfg,
    input  wire logic           i_job_valid,
    output logic                o_job_ready,
    input  wire oahi_pkg::t_job i_job,
    output logic                o_res_valid,
    input  wire logic           i_res_ready,
    output oahi_pkg::t_result   o_res
);
    import oahi_pkg::*;

    localparam int POS_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    t_bstate    r_state, n_state;
    logic [SLOTS-1:0] r_occ;
    logic [7:0] r_pos, n_pos;
    logic [7:0] r_delta, n_delta;
    logic [7:0] r_stepm, n_stepm;
    logic [7:0] r_coll, n_coll;
    logic       r_last, n_last;
    logic [15:0] r_total;
    t_result    r_out;
    logic       r_out_valid;

    logic [7:0]  inc1, inc2, coll_inc, res_coll;
    logic        hit, fail, finish, out_free;
    logic [16:0] sum;
    logic [15:0] total_sat;

    // One and two reduced modulo the table size.
    assign inc1 = (i_cfg.size == 8'd1) ? 8'd0 : 8'd1;
    assign inc2 = (i_cfg.size <= 8'd2) ? 8'd0 : 8'd2;

    assign hit      = r_occ[r_pos[POS_W-1:0]];
    assign coll_inc = r_coll + 8'd1;
    assign fail     = hit && (coll_inc == i_cfg.size);
    assign out_free = !r_out_valid || i_res_ready;
    assign res_coll = hit ? coll_inc : r_coll;
    assign sum       = {9'd0, res_coll} + {1'b0, r_total};
    assign total_sat = sum[16] ? 16'hFFFF : sum[15:0];

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_delta     = r_delta;
        n_stepm     = r_stepm;
        n_coll      = r_coll;
        n_last      = r_last;
        o_job_ready = 1'b0;
        finish      = 1'b0;
        case (r_state)
            B_IDLE: begin
                o_job_ready = 1'b1;
                if (i_job_valid) begin
                    n_pos   = i_job.home;
                    n_stepm = i_job.step;
                    n_delta = inc1;
                    n_coll  = '0;
                    n_last  = i_job.last;
                    n_state = B_PROBE;
                end
            end
            B_PROBE: begin
                if (!hit || fail) begin
                    if (out_free) begin
                        finish  = 1'b1;
                        n_state = B_IDLE;
                    end
                end else begin
                    n_coll = coll_inc;
                    case (i_cfg.mode)
                        MODE_QUAD: begin
                            n_pos   = add_mod(r_pos, r_delta, i_cfg.size);
                            n_delta = add_mod(r_delta, inc2, i_cfg.size);
                        end
                        MODE_DOUBLE: begin
                            n_pos = add_mod(r_pos, r_stepm, i_cfg.size);
                        end
                        default: begin
                            n_pos = add_mod(r_pos, inc1, i_cfg.size);
                        end
                    endcase
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_occ       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_occ   <= '0;
                    r_total <= '0;
                end else begin
                    r_total <= total_sat;
                    if (!hit) begin
                        r_occ[r_pos[POS_W-1:0]] <= 1'b1;
                    end
                end
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos   <= n_pos;
        r_delta <= n_delta;
        r_stepm <= n_stepm;
        r_coll  <= n_coll;
        r_last  <= n_last;
        if (finish) begin
            r_out.slot             <= hit ? 7'd0 : r_pos[6:0];
            r_out.placed           <= !hit;
            r_out.probe_collisions <= res_coll;
            r_out.total_collisions <= total_sat;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

`default_nettype wire

@@ rtl/open_address_hash_insert_unit.sv @@
// Top level of the open-addressing hash insert unit: configuration, front, queue and probe engine.
// Flow: an accepted key walks the front's remainder states F_KEY and F_STEP, one 4-bit
// digit per cycle in F_KEY, and waits in F_PUSH until the queue takes its job; the back
// then examines one slot per cycle until the key is placed or the table proves full.
// The front takes no new key until its job is pushed; the slower side sets throughput.
// Reset: synchronous active low; clears all occupancy bits, the batch total, the queue and
// both valid flags, and loads the registers with size 128, linear probing and prime 127.
`default_nettype none

module open_address_hash_insert_unit #(
    parameter int TABLE_DEPTH = 128
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [1:0]        i_cfg_idx,
    input  wire logic [7:0]        i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire oahi_pkg::t_item   i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output oahi_pkg::t_result      o_out_data
);
    import oahi_pkg::*;

    // The size register is eight bits wide, so no more than 255 slots can ever be probed.
    // Occupancy storage is sized to the smaller of the table depth and that limit.
    localparam int         SLOTS   = (TABLE_DEPTH < 255) ? TABLE_DEPTH : 255;
    localparam logic [7:0] SLOTS_B = 8'(SLOTS);

    logic [7:0] r_table_size;
    logic [1:0] r_probe_mode;
    logic [6:0] r_step_prime;
    t_cfg       cfg;

    logic job_valid_f, job_ready_f;
    t_job job_f;
    logic job_valid_b, job_ready_b;
    t_job job_b;

    // Configuration writes land directly. The user must write only while the block is idle;
    // it does not enforce this. The clamped values below feed both halves with no shadow copies.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= 8'd128;
            r_probe_mode <= MODE_LINEAR;
            r_step_prime <= 7'd127;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TABLE_SIZE: r_table_size <= i_cfg_data;
                CFG_PROBE_MODE: r_probe_mode <= i_cfg_data[1:0];
                CFG_STEP_PRIME: r_step_prime <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // A zero size acts as a single slot and sizes past the storage are clipped to it.
    // Primes below two act as two. The unused mode code falls through to linear probing
    // inside the probe engine.
    always_comb begin
        cfg.size  = r_table_size;
        if (r_table_size == 8'd0) begin
            cfg.size = 8'd1;
        end else if (r_table_size > SLOTS_B) begin
            cfg.size = SLOTS_B;
        end
        cfg.mode  = t_probe_mode'(r_probe_mode);
        cfg.prime = (r_step_prime < 7'd2) ? 7'd2 : r_step_prime;
    end

    // The front works the key modulo the table size and modulo the prime, digit by digit,
    // then reduces the double hash step modulo the table size.
    oahi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_job_valid (job_valid_f),
        .i_job_ready (job_ready_f),
        .o_job       (job_f)
    );

    // The queue lets the front start on the next key while the back is still probing.
    oahi_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (job_valid_f),
        .o_push_ready (job_ready_f),
        .i_push_data  (job_f),
        .o_pop_valid  (job_valid_b),
        .i_pop_ready  (job_ready_b),
        .o_pop_data   (job_b)
    );

    // The back examines one slot per cycle, stepping the position incrementally so that
    // no multiplier is needed for the quadratic or double hashing offsets. Its output
    // register holds a finished beat while the next job is already probing.
    oahi_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_job_valid (job_valid_b),
        .o_job_ready (job_ready_b),
        .i_job       (job_b),
        .o_res_valid (o_out_valid),
        .i_res_ready (i_out_ready),
        .o_res       (o_out_data)
    );

    // A failed insert reports slot zero and exactly one collision per usable slot.
    a_fail_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.placed) |->
            (o_out_data.slot == 7'd0) && (o_out_data.probe_collisions == cfg.size))
        else $error("failed insert with wrong slot or collision count");

    // A placed key met fewer occupied slots than the table holds.
    a_place_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.placed) |->
            (o_out_data.probe_collisions < cfg.size))
        else $error("placed key reports too many collisions");

    // The front takes one key at a time and is busy right after accepting a beat.
    a_front_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("front accepted a second key while still working");

endmodule

`default_nettype wire

@@ verif/tb_open_address_hash_insert_unit.sv @@
// Self-checking testbench for the open-addressing hash insert unit.
`default_nettype none

module tb_open_address_hash_insert_unit;
    import oahi_pkg::*;

    localparam int TABLE_DEPTH = 128;
    // Probe mode code that the package leaves unnamed; the block probes it like linear.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    // Cycles the result side refuses beats during the back-pressure test.
    localparam int HOLD_CYCLES = 200;
    // Cycles allowed after the last result for anything stray to show up.
    localparam int SETTLE_CYCLES = 40;
    localparam int TIMEOUT_CYCLES = 3000000;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_TABLE_SIZE;
    logic [7:0] i_cfg_data = 8'd0;
    logic     i_in_valid = 1'b0;
    logic     o_in_ready;
    t_item    i_in_data = '0;
    logic     o_out_valid;
    logic     i_out_ready = 1'b0;
    t_result  o_out_data;

    open_address_hash_insert_unit #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    // Shadow of the configuration registers, as written.
    logic [7:0] cfg_size = 8'd128;
    logic [1:0] cfg_mode = MODE_LINEAR;
    logic [6:0] cfg_prime = 7'd127;

    // Shadow of the table: occupancy bits and the saturating batch total.
    bit          slot_used [TABLE_DEPTH];
    int unsigned batch_total = 0;

    t_result pending_results [$];
    int      error_count = 0;
    bit      send_gaps = 1'b1;
    bit      recv_gaps = 1'b1;
    bit      recv_hold_req = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_gap(input bit enabled);
        return enabled ? int'($urandom_range(0, 10)) : 0;
    endfunction

    function automatic int unsigned eff_table_size();
        if (cfg_size == 8'd0) return 1;
        if (cfg_size > TABLE_DEPTH) return TABLE_DEPTH;
        return cfg_size;
    endfunction

    // Inserts one key into the shadow table and returns the result the block must give.
    function automatic t_result predict_insert(input logic [30:0] key, input logic last);
        t_result     r;
        int unsigned k;
        int unsigned t;
        int unsigned p;
        int unsigned home;
        int unsigned pos;
        int unsigned coll;
        longint unsigned stride;
        longint unsigned j;
        longint unsigned off;
        bit          ok;
        k = key;
        t = eff_table_size();
        p = (cfg_prime < 7'd2) ? 2 : cfg_prime;
        home = k % t;
        stride = p - (k % p);
        pos = home;
        coll = 0;
        ok = 1'b0;
        j = 0;
        // At most t positions are examined; a full sweep of collisions means no room.
        while (coll < t) begin
            if (j != 0) begin
                case (cfg_mode)
                    MODE_QUAD:   off = j * j;
                    MODE_DOUBLE: off = j * stride;
                    default:     off = j;
                endcase
                pos = int'((home + off) % t);
            end
            if (!slot_used[pos]) begin
                ok = 1'b1;
                break;
            end
            coll++;
            j++;
        end
        // A failed insert writes nothing but its collisions still count.
        if (ok) slot_used[pos] = 1'b1;
        batch_total = batch_total + coll;
        if (batch_total > 65535) batch_total = 65535;
        r.slot = ok ? 7'(pos) : 7'd0;
        r.placed = ok;
        r.probe_collisions = (coll > 255) ? 8'd255 : 8'(coll);
        r.total_collisions = 16'(batch_total);
        if (last) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            batch_total = 0;
        end
        return r;
    endfunction

    // Offers one key and returns at the edge where its beat is taken.
    task automatic send_key(input logic [30:0] key, input logic last);
        int gap;
        gap = draw_gap(send_gaps);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{key: key, batch_end: last};
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_insert(key, last));
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic wait_results_done();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    // Writes all three registers on consecutive edges; the block must be idle.
    task automatic program_regs(input logic [7:0] size, input logic [1:0] mode,
                                input logic [6:0] prime);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TABLE_SIZE;
        i_cfg_data <= size;
        @(posedge i_clk);
        i_cfg_idx <= CFG_PROBE_MODE;
        i_cfg_data <= {6'd0, mode};
        @(posedge i_clk);
        i_cfg_idx <= CFG_STEP_PRIME;
        i_cfg_data <= {1'b0, prime};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_size = size;
        cfg_mode = mode;
        cfg_prime = prime;
    endtask

    // Result side: checks every beat against the oldest expectation and
    // draws a fresh stall after each beat, or a long hold when one is asked for.
    initial begin
        t_result want;
        int      wait_left;
        bit      beat;
        wait_left = 0;
        forever begin
            @(posedge i_clk);
            beat = i_rst_n && o_out_valid && i_out_ready;
            if (beat) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no expectation pending: %p", o_out_data);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (o_out_data.slot !== want.slot) begin
                        $error("slot mismatch: expected %0d, actual %0d",
                               want.slot, o_out_data.slot);
                        error_count++;
                    end
                    if (o_out_data.placed !== want.placed) begin
                        $error("placed mismatch: expected %0d, actual %0d",
                               want.placed, o_out_data.placed);
                        error_count++;
                    end
                    if (o_out_data.probe_collisions !== want.probe_collisions) begin
                        $error("probe_collisions mismatch: expected %0d, actual %0d",
                               want.probe_collisions, o_out_data.probe_collisions);
                        error_count++;
                    end
                    if (o_out_data.total_collisions !== want.total_collisions) begin
                        $error("total_collisions mismatch: expected %0d, actual %0d",
                               want.total_collisions, o_out_data.total_collisions);
                        error_count++;
                    end
                end
            end
            if (beat || recv_hold_req) begin
                wait_left = recv_hold_req ? HOLD_CYCLES : draw_gap(recv_gaps);
                recv_hold_req = 1'b0;
                if (wait_left > 0) i_out_ready <= 1'b0;
            end else if (!i_out_ready) begin
                if (wait_left > 0) wait_left--;
                if (wait_left == 0) i_out_ready <= 1'b1;
            end
        end
    end

    // Reset register values: home slot wrap at the top of the table and the extreme keys.
    task automatic test_reset_defaults();
        send_key(31'd0, 1'b0);
        send_key(31'h7FFF_FFFF, 1'b0);
        send_key(31'd128, 1'b0);
        send_key(31'd255, 1'b1);
        wait_results_done();
    endtask

    // A table of four slots filled by one home slot, then an insert that finds no room.
    task automatic test_full_table();
        program_regs(8'd4, MODE_LINEAR, 7'd3);
        send_key(31'd0, 1'b0);
        send_key(31'd4, 1'b0);
        send_key(31'd8, 1'b0);
        send_key(31'd12, 1'b0);
        send_key(31'd16, 1'b1);
        wait_results_done();
    endtask

    // The unnamed mode code steps like linear probing.
    task automatic test_unused_mode();
        program_regs(8'd5, MODE_UNUSED, 7'd3);
        send_key(31'd4, 1'b0);
        send_key(31'd9, 1'b1);
        wait_results_done();
    endtask

    // Quadratic steps in eight slots reach only three of them, so the fourth key fails.
    task automatic test_quadratic();
        program_regs(8'd8, MODE_QUAD, 7'd7);
        send_key(31'd0, 1'b0);
        send_key(31'd8, 1'b0);
        send_key(31'd16, 1'b0);
        send_key(31'd24, 1'b1);
        wait_results_done();
    endtask

    // Double hashing with a legal prime, then with primes of zero and one taken as two.
    task automatic test_double_hash();
        program_regs(8'd11, MODE_DOUBLE, 7'd7);
        send_key(31'd0, 1'b0);
        send_key(31'd11, 1'b0);
        send_key(31'd22, 1'b1);
        wait_results_done();
        program_regs(8'd6, MODE_DOUBLE, 7'd0);
        send_key(31'd0, 1'b0);
        send_key(31'd6, 1'b0);
        send_key(31'd12, 1'b0);
        send_key(31'd18, 1'b1);
        wait_results_done();
        program_regs(8'd5, MODE_DOUBLE, 7'd1);
        send_key(31'd3, 1'b0);
        send_key(31'd8, 1'b1);
        wait_results_done();
    endtask

    // Size zero acts as one slot, sizes above the table act as the full table,
    // and a smaller size mid-batch keeps the occupancy already there.
    task automatic test_size_limits();
        program_regs(8'd0, MODE_LINEAR, 7'd127);
        send_key(31'h5555_5555, 1'b0);
        send_key(31'h2AAA_AAAA, 1'b1);
        wait_results_done();
        program_regs(8'd255, MODE_LINEAR, 7'd127);
        send_key(31'h7FFF_FFFF, 1'b0);
        send_key(31'd5, 1'b0);
        wait_results_done();
        program_regs(8'd16, MODE_LINEAR, 7'd13);
        send_key(31'd21, 1'b0);
        send_key(31'd127, 1'b1);
        wait_results_done();
    endtask

    // Fill the whole table, then keep failing inserts until the batch total saturates.
    task automatic test_total_saturation();
        program_regs(8'd128, MODE_LINEAR, 7'd127);
        send_gaps = 1'b0;
        for (int i = 0; i < 128 + 520; i++) begin
            send_key(31'($urandom), i == 128 + 519);
        end
        send_gaps = 1'b1;
        wait_results_done();
    endtask

    // The result side holds off for a long stretch while keys keep coming,
    // so the block fills up and stalls its input; then the sender waits for all results.
    task automatic test_backpressure();
        program_regs(8'd32, MODE_DOUBLE, 7'd31);
        send_gaps = 1'b0;
        recv_hold_req = 1'b1;
        for (int i = 0; i < 20; i++) begin
            send_key(31'($urandom_range(0, 200)), i == 19);
        end
        send_gaps = 1'b1;
        wait_results_done();
    endtask

    // Phases of random configuration, each followed by a mix of colliding
    // and spread-out keys with batch ends often enough to restart the table.
    task automatic test_random_phases(input int n_keys);
        int          sent;
        int          phase_len;
        int unsigned t;
        logic [7:0]  size;
        logic [6:0]  prime;
        logic [30:0] key;
        logic        last;
        sent = 0;
        while (sent < n_keys) begin
            case ($urandom_range(0, 9))
                0:       size = 8'd0;
                1:       size = 8'd1;
                2:       size = 8'd128;
                3:       size = 8'($urandom_range(129, 255));
                default: size = 8'($urandom_range(2, 128));
            endcase
            prime = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(0, 1))
                                                 : 7'($urandom_range(2, 127));
            program_regs(size, 2'($urandom_range(0, 3)), prime);
            send_gaps = ($urandom_range(0, 3) != 0);
            recv_gaps = ($urandom_range(0, 3) != 0);
            t = eff_table_size();
            phase_len = $urandom_range(20, 60);
            for (int i = 0; i < phase_len; i++) begin
                case ($urandom_range(0, 2))
                    0:       key = 31'($urandom);
                    1:       key = 31'($urandom_range(0, 4 * t));
                    default: key = 31'($urandom_range(0, 1000000) * t + $urandom_range(0, 3));
                endcase
                last = ($urandom_range(0, t / 2 + 2) == 0);
                send_key(key, last);
                sent++;
            end
            wait_results_done();
        end
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_full_table();
        test_unused_mode();
        test_quadratic();
        test_double_hash();
        test_size_limits();
        test_total_saturation();
        test_backpressure();
        test_random_phases(420);
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

@@ open_address_hash_insert_unit.f @@
rtl/oahi_pkg.sv
rtl/oahi_front.sv
rtl/oahi_queue.sv
rtl/oahi_back.sv
rtl/open_address_hash_insert_unit.sv
verif/tb_open_address_hash_insert_unit.sv
